>>> rtl/ktl_pkg.sv
// ktl_pkg: shared constants, result type and decode functions for the keyword token lexer.
// No dependencies; used by ktl_if.sv and keyword_token_lexer_top.sv.
`timescale 1ns / 1ps

package ktl_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int KIND_W          = 5;
    localparam int FIELD_W         = 16;

    localparam logic [KIND_W-1:0] KIND_FUNC     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_SYMBOL   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd3;
    localparam logic [KIND_W-1:0] KIND_COLON    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 5'd5;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 5'd6;
    localparam logic [KIND_W-1:0] KIND_LOCAL    = 5'd7;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_WHILE    = 5'd10;
    localparam logic [KIND_W-1:0] KIND_GT       = 5'd11;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 5'd12;
    localparam logic [KIND_W-1:0] KIND_MINUS_EQ = 5'd13;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 5'd14;
    localparam logic [KIND_W-1:0] KIND_NEWLINE  = 5'd15;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 5'd16;
    localparam logic [KIND_W-1:0] KIND_END      = 5'd17;

    localparam logic [39:0] KW_WHILE = "while";
    localparam logic [31:0] KW_FUNC  = "func";
    localparam logic [39:0] KW_LOCAL = "local";

    localparam logic [7:0] CHAR_MINUS = "-";
    localparam logic [7:0] CHAR_EQ    = "=";
    localparam logic [7:0] CHAR_NL    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = " ";
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               last;
    } result_t;

    // bit0 while, bit1 func, bit2 local: keyword char at idx equals b
    function automatic logic [2:0] kw_match(input logic [2:0] idx, input logic [7:0] b);
        logic [2:0] m;
        m = '0;
        if (idx < 3'd5)
        begin
            m[0] = (KW_WHILE[8*(4-int'(idx)) +: 8] == b);
            m[2] = (KW_LOCAL[8*(4-int'(idx)) +: 8] == b);
        end
        if (idx < 3'd4)
        begin
            m[1] = (KW_FUNC[8*(3-int'(idx)) +: 8] == b);
        end
        return m;
    endfunction

    function automatic logic [KIND_W-1:0] sym_kind(input logic [2:0] hits,
                                                  input logic len5, input logic len4);
        logic [KIND_W-1:0] k;
        priority if (hits[0] && len5) k = KIND_WHILE;
        else if (hits[1] && len4)     k = KIND_FUNC;
        else if (hits[2] && len5)     k = KIND_LOCAL;
        else                          k = KIND_SYMBOL;
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        unique case (b)
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ":":     k = KIND_COLON;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "=":     k = KIND_ASSIGN;
            ">":     k = KIND_GT;
            "+":     k = KIND_PLUS;
            CHAR_NL: k = KIND_NEWLINE;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0" && b <= "9");
    endfunction

endpackage

>>> rtl/ktl_if.sv
// ktl_if: valid/ready channel interfaces for text bytes in and tokens out.
// Depends on ktl_pkg for field widths.
`timescale 1ns / 1ps

interface ktl_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_final;

    modport source (output valid, text_byte, is_final, input ready);
    modport sink   (input valid, text_byte, is_final, output ready);
endinterface

interface ktl_token_if;
    logic                         valid;
    logic                         ready;
    logic [ktl_pkg::KIND_W-1:0]   token_kind;
    logic [ktl_pkg::FIELD_W-1:0]  start_offset;
    logic [ktl_pkg::FIELD_W-1:0]  token_length;
    logic                         last_of_run;

    modport source (output valid, token_kind, start_offset, token_length, last_of_run,
                    input ready);
    modport sink   (input valid, token_kind, start_offset, token_length, last_of_run,
                    output ready);
endinterface

>>> rtl/keyword_token_lexer_top.sv
// keyword_token_lexer_top: streaming lexer, one text byte per transaction in,
// tokens out through a three-entry result queue. Depends on ktl_pkg and ktl_if.
// A byte's first token is registered into the queue and is output in the next cycle.
// Throughput: one byte per cycle while each byte yields at most one token and the
// output is ready; a byte yielding more tokens (up to 3) holds the input until the
// single output port drains the queue to one entry, one per cycle while ready.
// Reset: rst_n clears the scan state to idle, offsets to zero and empties the queue.
`timescale 1ns / 1ps

module keyword_token_lexer_top #(
    parameter int OFFSET_BITS = ktl_pkg::OFFSET_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ktl_text_if.sink    text_ch,
    ktl_token_if.source token_ch
);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_SYM   = 3'd1;
    localparam logic [2:0] MODE_NUM   = 3'd2;
    localparam logic [2:0] MODE_MINUS = 3'd3;
    localparam logic [2:0] MODE_ERR   = 3'd4;

    localparam logic [OFFSET_BITS-1:0] LEN_MAX = '1;

    function automatic logic [ktl_pkg::FIELD_W-1:0] to16(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+ktl_pkg::FIELD_W-1:0] w;
        w = {{ktl_pkg::FIELD_W{1'b0}}, v};
        return w[ktl_pkg::FIELD_W-1:0];
    endfunction

    function automatic logic pending(input logic [2:0] m);
        return (m == MODE_SYM) || (m == MODE_NUM) || (m == MODE_MINUS);
    endfunction

    function automatic ktl_pkg::result_t flush_tok(input logic [2:0] m,
                                                   input logic [OFFSET_BITS-1:0] st,
                                                   input logic [OFFSET_BITS-1:0] ln,
                                                   input logic [2:0] hits);
        ktl_pkg::result_t r;
        r.start  = to16(st);
        r.length = to16(ln);
        r.last   = 1'b0;
        unique case (m)
            MODE_SYM:   r.kind = ktl_pkg::sym_kind(hits, ln == OFFSET_BITS'(5),
                                                   ln == OFFSET_BITS'(4));
            MODE_NUM:   r.kind = ktl_pkg::KIND_NUMBER;
            default:
            begin
                r.kind   = ktl_pkg::KIND_MINUS;
                r.length = 16'd1;
            end
        endcase
        return r;
    endfunction

    logic [2:0]             mode_reg,  mode_next;
    logic [OFFSET_BITS-1:0] off_reg,   off_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] len_reg,   len_next;
    logic [2:0]             hits_reg,  hits_next;

    ktl_pkg::result_t q_reg [3];
    ktl_pkg::result_t q_next [3];
    logic [1:0]       cnt_reg, cnt_next;

    logic [7:0]             b;
    logic                   fin;
    logic                   accept;
    logic                   pop;
    logic                   handled;
    logic [OFFSET_BITS-1:0] len_inc;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [2:0]             hits_ext;
    ktl_pkg::result_t       c0, c1, c2;
    logic                   c0_v, c1_v, c2_v;
    ktl_pkg::result_t       grp [3];
    logic [1:0]             grp_n;

    assign b       = text_ch.text_byte;
    assign fin     = text_ch.is_final;
    assign pop     = token_ch.valid && token_ch.ready;
    assign text_ch.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && token_ch.ready);
    assign accept  = text_ch.valid && text_ch.ready;

    assign len_inc  = (len_reg == LEN_MAX) ? len_reg : len_reg + 1'b1;
    assign off_inc  = off_reg + 1'b1;
    assign hits_ext = (len_reg < OFFSET_BITS'(5)) ? ktl_pkg::kw_match(len_reg[2:0], b) : 3'b000;

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        hits_next  = hits_reg;
        handled    = 1'b0;
        c0_v       = 1'b0;
        c0         = flush_tok(mode_reg, start_reg, len_reg, hits_reg);
        c1_v       = 1'b0;
        c1         = '0;

        unique case (mode_reg)
            MODE_ERR:
            begin
                handled = 1'b1;
            end
            MODE_MINUS:
            begin
                c0_v      = 1'b1;
                mode_next = MODE_IDLE;
                if (b == ktl_pkg::CHAR_EQ)
                begin
                    c0.kind   = ktl_pkg::KIND_MINUS_EQ;
                    c0.length = 16'd2;
                    handled   = 1'b1;
                end
            end
            MODE_SYM:
            begin
                if (ktl_pkg::is_alpha(b) || ktl_pkg::is_digit(b))
                begin
                    hits_next = hits_reg & hits_ext;
                    len_next  = len_inc;
                    handled   = 1'b1;
                end
                else
                begin
                    c0_v      = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUM:
            begin
                if (ktl_pkg::is_digit(b))
                begin
                    len_next = len_inc;
                    handled  = 1'b1;
                end
                else
                begin
                    c0_v      = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (!handled)
        begin
            priority if (b == ktl_pkg::CHAR_SPACE || b == ktl_pkg::CHAR_TAB)
            begin
            end
            else if (ktl_pkg::is_alpha(b))
            begin
                mode_next  = MODE_SYM;
                start_next = off_reg;
                len_next   = OFFSET_BITS'(1);
                hits_next  = ktl_pkg::kw_match(3'd0, b);
            end
            else if (ktl_pkg::is_digit(b))
            begin
                mode_next  = MODE_NUM;
                start_next = off_reg;
                len_next   = OFFSET_BITS'(1);
            end
            else if (b == ktl_pkg::CHAR_MINUS)
            begin
                mode_next  = MODE_MINUS;
                start_next = off_reg;
                len_next   = OFFSET_BITS'(1);
            end
            else
            begin
                c1_v      = 1'b1;
                c1.kind   = ktl_pkg::punct_kind(b);
                c1.start  = to16(off_reg);
                c1.length = 16'd1;
                c1.last   = 1'b0;
                if (c1.kind == ktl_pkg::KIND_ERROR)
                begin
                    mode_next = MODE_ERR;
                end
            end
        end

        // end of text flushes the token still open after this byte
        if (!c1_v && fin && pending(mode_next))
        begin
            c1_v = 1'b1;
            c1   = flush_tok(mode_next, start_next, len_next, hits_next);
        end

        c2_v      = fin;
        c2.kind   = ktl_pkg::KIND_END;
        c2.start  = to16(off_inc);
        c2.length = '0;
        c2.last   = 1'b0;

        off_next = off_inc;
        if (fin)
        begin
            mode_next  = MODE_IDLE;
            off_next   = '0;
            start_next = '0;
            len_next   = '0;
            hits_next  = 3'b111;
        end
    end

    always_comb
    begin
        grp[0] = c0_v ? c0 : (c1_v ? c1 : c2);
        grp[1] = (c0_v && c1_v) ? c1 : c2;
        grp[2] = c2;
        grp_n  = 2'(c0_v) + 2'(c1_v) + 2'(c2_v);
        grp[0].last = (grp_n == 2'd1);
        grp[1].last = (grp_n == 2'd2);
        grp[2].last = (grp_n == 2'd3);
    end

    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            q_next   = grp;
            cnt_next = grp_n;
        end
        else if (pop)
        begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            off_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            hits_reg  <= 3'b111;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                mode_reg  <= mode_next;
                off_reg   <= off_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                hits_reg  <= hits_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign token_ch.valid        = (cnt_reg != 2'd0);
    assign token_ch.token_kind   = q_reg[0].kind;
    assign token_ch.start_offset = q_reg[0].start;
    assign token_ch.token_length = q_reg[0].length;
    assign token_ch.last_of_run  = q_reg[0].last;

endmodule
